// ===== hw/rtl/mbrp_pkg.sv =====
// Shared types and constants for the MBR partition table parser.
package mbrp_pkg;

    localparam int NUM_ENTRIES = 4;

    localparam logic [8:0] TABLE_BASE = 9'd446;
    localparam logic [8:0] SIG_POS    = 9'd510;
    localparam logic [8:0] LAST_POS   = 9'd511;

    localparam logic [3:0] OFF_STATUS    = 4'd0;
    localparam logic [3:0] OFF_TYPE      = 4'd4;
    localparam logic [3:0] OFF_LBA_FIRST = 4'd8;
    localparam logic [3:0] OFF_LEN_FIRST = 4'd12;

    localparam logic [7:0] ACTIVE_MARK = 8'h80;
    localparam logic [7:0] SIG_BYTE0   = 8'h55;
    localparam logic [7:0] SIG_BYTE1   = 8'hAA;

    localparam logic STATUS_OK      = 1'b0;
    localparam logic STATUS_BAD_SIG = 1'b1;

    localparam logic [1:0] LAST_ENTRY = 2'd3;

    typedef struct packed {
        logic        active;
        logic [7:0]  part_type;
        logic [31:0] first_lba;
        logic [31:0] lba_count;
    } mbrp_entry_t;

    // Snapshot of one sector's table, handed from the front to the back.
    typedef struct packed {
        mbrp_entry_t [NUM_ENTRIES-1:0] entries;
        logic                          sig_ok;
        logic                          active_found;
        logic [1:0]                    active_index;
    } mbrp_sector_t;

    // Handshake between the queue and the back end.
    typedef struct packed {
        logic         avail;
        mbrp_sector_t head;
    } mbrp_qout_t;

endpackage

// ===== hw/rtl/mbrp_if.sv =====
// Channel interfaces for sector bytes and parsed partition results.
interface mbrp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] sector_byte;

    modport source (output valid, output sector_byte, input ready);
    modport sink   (input valid, input sector_byte, output ready);
endinterface

interface mbrp_result_if;
    logic        valid;
    logic        ready;
    logic        status;
    logic [1:0]  entry_index;
    logic        bootable;
    logic [7:0]  part_type;
    logic [31:0] first_lba;
    logic [31:0] lba_count;
    logic        active_found;
    logic [1:0]  active_index;
    logic        last;

    modport source (
        output valid, output status, output entry_index, output bootable,
        output part_type, output first_lba, output lba_count,
        output active_found, output active_index, output last,
        input ready
    );
    modport sink (
        input valid, input status, input entry_index, input bootable,
        input part_type, input first_lba, input lba_count,
        input active_found, input active_index, input last,
        output ready
    );
endinterface

// ===== hw/rtl/mbrp_front.sv =====
// Front end: byte position tracking, table capture and sector snapshot.
module mbrp_front (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  byte_valid,
    input  logic [7:0]            byte_data,
    output logic                  byte_ready,
    input  logic                  queue_full,
    output logic                  push,
    output mbrp_pkg::mbrp_sector_t push_data
);
    import mbrp_pkg::*;

    logic [8:0]  pos_reg;
    logic [8:0]  pos_next;
    mbrp_entry_t entries_reg [NUM_ENTRIES];
    logic        sig0_ok_reg;
    logic        sig0_ok_next;

    logic        take;
    logic        in_table;
    logic [8:0]  rel;
    logic [1:0]  ent;
    logic [3:0]  off;
    logic        found;
    logic [1:0]  aidx;

    // Only the closing byte needs room in the queue.
    assign byte_ready = (pos_reg != LAST_POS) || !queue_full;
    assign take       = byte_valid && byte_ready;
    assign in_table   = (pos_reg >= TABLE_BASE) && (pos_reg < SIG_POS);
    assign rel        = pos_reg - TABLE_BASE;
    assign ent        = rel[5:4];
    assign off        = rel[3:0];

    always_comb
    begin
        found = 1'b0;
        aidx  = 2'd0;
        for (int i = NUM_ENTRIES - 1; i >= 0; i--)
        begin
            if (entries_reg[i].active && (entries_reg[i].part_type != 8'd0))
            begin
                found = 1'b1;
                aidx  = 2'(i);
            end
        end
    end

    always_comb
    begin
        pos_next     = pos_reg;
        sig0_ok_next = sig0_ok_reg;
        if (take)
        begin
            pos_next = pos_reg + 9'd1;
            if (pos_reg == SIG_POS)
            begin
                sig0_ok_next = (byte_data == SIG_BYTE0);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg     <= 9'd0;
            sig0_ok_reg <= 1'b0;
        end
        else
        begin
            pos_reg     <= pos_next;
            sig0_ok_reg <= sig0_ok_next;
        end
    end

    // Captured fields start at zero so a first sector matches a cleared table.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_ENTRIES; i++)
            begin
                entries_reg[i] <= '0;
            end
        end
        else if (take && in_table)
        begin
            if (off == OFF_STATUS)
            begin
                entries_reg[ent].active <= (byte_data == ACTIVE_MARK);
            end
            else if (off == OFF_TYPE)
            begin
                entries_reg[ent].part_type <= byte_data;
            end
            else if ((off >= OFF_LBA_FIRST) && (off < OFF_LEN_FIRST))
            begin
                entries_reg[ent].first_lba[off[1:0]*8 +: 8] <= byte_data;
            end
            else if (off >= OFF_LEN_FIRST)
            begin
                entries_reg[ent].lba_count[off[1:0]*8 +: 8] <= byte_data;
            end
        end
    end

    assign push = take && (pos_reg == LAST_POS);

    always_comb
    begin
        for (int i = 0; i < NUM_ENTRIES; i++)
        begin
            push_data.entries[i] = entries_reg[i];
        end
        push_data.sig_ok       = sig0_ok_reg && (byte_data == SIG_BYTE1);
        push_data.active_found = found;
        push_data.active_index = aidx;
    end

endmodule

// ===== hw/rtl/mbrp_queue.sv =====
// Short queue of sector snapshots between the front and back ends.
module mbrp_queue #(
    parameter int DEPTH = 2
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  mbrp_pkg::mbrp_sector_t push_data,
    output logic                   full,
    input  logic                   pop,
    output mbrp_pkg::mbrp_qout_t   qout
);
    import mbrp_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_MAX = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(DEPTH);

    mbrp_sector_t     slots_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    assign full       = (count_reg == CNT_MAX);
    assign qout.avail = (count_reg != '0);
    assign qout.head  = slots_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && qout.avail;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_MAX) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_MAX) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slots_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== hw/rtl/mbrp_back.sv =====
// Back end: expands each sector snapshot into result transactions.
module mbrp_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  mbrp_pkg::mbrp_qout_t qout,
    output logic                 pop,
    mbrp_result_if.source        result
);
    import mbrp_pkg::*;

    logic        valid_reg;
    logic        valid_next;
    logic [1:0]  idx_reg;
    logic [1:0]  idx_next;
    logic        status_reg;
    logic [1:0]  entry_index_reg;
    logic        bootable_reg;
    logic [7:0]  part_type_reg;
    logic [31:0] first_lba_reg;
    logic [31:0] lba_count_reg;
    logic        active_found_reg;
    logic [1:0]  active_index_reg;
    logic        last_reg;

    logic        load;
    logic        load_last;
    mbrp_entry_t cur;

    assign load      = qout.avail && (!valid_reg || result.ready);
    assign load_last = !qout.head.sig_ok || (idx_reg == LAST_ENTRY);
    assign cur       = qout.head.entries[idx_reg];
    assign pop       = load && load_last;

    always_comb
    begin
        valid_next = valid_reg;
        idx_next   = idx_reg;
        if (load)
        begin
            valid_next = 1'b1;
            idx_next   = load_last ? 2'd0 : idx_reg + 2'd1;
        end
        else if (result.ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= 2'd0;
        end
        else
        begin
            valid_reg <= valid_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            active_found_reg <= qout.head.active_found;
            active_index_reg <= qout.head.active_index;
            last_reg         <= load_last;
            if (qout.head.sig_ok)
            begin
                status_reg      <= STATUS_OK;
                entry_index_reg <= idx_reg;
                bootable_reg    <= cur.active;
                part_type_reg   <= cur.part_type;
                first_lba_reg   <= cur.first_lba;
                lba_count_reg   <= cur.lba_count;
            end
            else
            begin
                status_reg      <= STATUS_BAD_SIG;
                entry_index_reg <= 2'd0;
                bootable_reg    <= 1'b0;
                part_type_reg   <= 8'd0;
                first_lba_reg   <= 32'd0;
                lba_count_reg   <= 32'd0;
            end
        end
    end

    assign result.valid        = valid_reg;
    assign result.status       = status_reg;
    assign result.entry_index  = entry_index_reg;
    assign result.bootable     = bootable_reg;
    assign result.part_type    = part_type_reg;
    assign result.first_lba    = first_lba_reg;
    assign result.lba_count    = lba_count_reg;
    assign result.active_found = active_found_reg;
    assign result.active_index = active_index_reg;
    assign result.last         = last_reg;

endmodule

// ===== hw/rtl/mbr_partition_table_parser_top.sv =====
// Top level of the MBR partition table parser.
//
// The sector channel takes one 512-byte boot sector as a stream of byte
// transactions, offset 0 first; the position is counted inside the block and
// wraps to zero after offset 511, so sectors simply follow one another.
// The result channel carries, for each sector, four entry transactions
// (entry 0 to 3, last set on entry 3) when the signature 0x55 0xAA is
// present, or a single transaction with the bad-signature status and zeroed
// entry fields otherwise. Every transaction also reports the lowest entry
// that is marked active and has a nonzero type.
//
// Throughput is one byte per cycle, but for a closing byte held by a full
// queue. A sector's results follow one per cycle while the receiver is
// ready; at most four results per 512 bytes leave the output side far from busy.
// A snapshot queue of QUEUE_DEPTH sectors sits between the capture logic and
// the result generator. If the receiver stalls, the output register holds
// its transaction and bytes keep flowing; only the closing byte of a sector
// waits, and only when the queue is full.
// Reset empties the queue, clears the output and returns the position to
// offset zero with a cleared table.
module mbr_partition_table_parser_top #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic          clk,
    input  logic          rst_n,
    mbrp_byte_if.sink     sector,
    mbrp_result_if.source result
);
    import mbrp_pkg::*;

    logic         queue_full;
    logic         push;
    mbrp_sector_t push_data;
    logic         pop;
    mbrp_qout_t   qout;

    mbrp_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (sector.valid),
        .byte_data  (sector.sector_byte),
        .byte_ready (sector.ready),
        .queue_full (queue_full),
        .push       (push),
        .push_data  (push_data)
    );

    mbrp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (queue_full),
        .pop       (pop),
        .qout      (qout)
    );

    mbrp_back u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .qout   (qout),
        .pop    (pop),
        .result (result)
    );

endmodule

// ===== hw/rtl/mbrp_checker.sv =====
// Port-level checks for the MBR partition table parser, bound to the top.
module mbrp_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic        status,
    input logic [1:0]  entry_index,
    input logic [31:0] first_lba,
    input logic        last
);
    import mbrp_pkg::*;

    a_hold_when_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(entry_index) && $stable(last))
        else $error("result changed while stalled");

    a_bad_sig_single: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == STATUS_BAD_SIG) |->
            last && (entry_index == 2'd0) && (first_lba == 32'd0))
        else $error("bad signature result malformed");

    a_last_on_entry3: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == STATUS_OK) |-> (last == (entry_index == LAST_ENTRY)))
        else $error("last flag misplaced");

    a_entries_follow: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !last |=>
            out_valid && (status == STATUS_OK) &&
            (entry_index == $past(entry_index) + 2'd1))
        else $error("entry results not consecutive");

endmodule

bind mbr_partition_table_parser_top mbrp_checker u_mbrp_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (result.valid),
    .out_ready   (result.ready),
    .status      (result.status),
    .entry_index (result.entry_index),
    .first_lba   (result.first_lba),
    .last        (result.last)
);

// ===== tb/mbr_partition_table_parser_top_test.sv =====
// Self-checking testbench for the MBR partition table parser top level.
`timescale 1ns / 100ps

module mbr_partition_table_parser_top_test;

    import mbrp_pkg::*;

    localparam realtime CLK_PERIOD   = 12.0;
    localparam int      RESET_CYCLES = 10;
    localparam int      RANDOM_SECTORS = 20;
    // Results checked before the receiver's long hold-off begins; by then the
    // directed sectors are done and the random sectors are streaming.
    localparam int      HOLD_AFTER_RESULTS = 45;
    // Long enough for several sectors to pile up behind the output register.
    localparam int      LONG_HOLD_CYCLES = 4000;
    localparam int      DRAIN_CYCLES = 20;
    localparam int      MAX_REPORTS = 10;

    // One partition result as seen on the result channel.
    typedef struct packed {
        logic        status;
        logic [1:0]  entry_index;
        logic        bootable;
        logic [7:0]  part_type;
        logic [31:0] first_lba;
        logic [31:0] lba_count;
        logic        active_found;
        logic [1:0]  active_index;
        logic        last;
    } part_result_t;

    // One sector of stimulus: the four table entries and the two signature
    // bytes. The remaining bytes of the sector (boot code and CHS fields) are
    // filled with random values when the sector is sent. Where typed is set,
    // the expected status and active search outcome are written in the row.
    typedef struct packed {
        logic [0:3][7:0]  boot;
        logic [0:3][7:0]  ptype;
        logic [0:3][31:0] lba;
        logic [0:3][31:0] len;
        logic [7:0]       sig0;
        logic [7:0]       sig1;
        logic             typed;
        logic             exp_status;
        logic             exp_found;
        logic [1:0]       exp_index;
    } sector_row_t;

    localparam int DIRECTED_ROWS = 13;

    localparam sector_row_t DIRECTED [DIRECTED_ROWS] = '{
        // Straight after reset: an empty sector without a signature.
        '{'{8'h00, 8'h00, 8'h00, 8'h00}, '{8'h00, 8'h00, 8'h00, 8'h00},
          '{32'h0, 32'h0, 32'h0, 32'h0}, '{32'h0, 32'h0, 32'h0, 32'h0},
          8'h00, 8'h00, 1'b1, STATUS_BAD_SIG, 1'b0, 2'd0},
        // Empty table with a good signature: four unused entries.
        '{'{8'h00, 8'h00, 8'h00, 8'h00}, '{8'h00, 8'h00, 8'h00, 8'h00},
          '{32'h0, 32'h0, 32'h0, 32'h0}, '{32'h0, 32'h0, 32'h0, 32'h0},
          SIG_BYTE0, SIG_BYTE1, 1'b1, STATUS_OK, 1'b0, 2'd0},
        // Entry 0 active, start at zero and the largest possible length.
        '{'{ACTIVE_MARK, 8'h00, 8'h00, 8'h00}, '{8'h07, 8'h00, 8'h00, 8'h00},
          '{32'h0, 32'h0, 32'h0, 32'h0}, '{32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0},
          SIG_BYTE0, SIG_BYTE1, 1'b1, STATUS_OK, 1'b1, 2'd0},
        // All entries flagged active but only entry 3 has a type.
        '{'{ACTIVE_MARK, ACTIVE_MARK, ACTIVE_MARK, ACTIVE_MARK},
          '{8'h00, 8'h00, 8'h00, 8'hFF},
          '{32'h0, 32'h0, 32'h0, 32'hFFFF_FFFF}, '{32'h0, 32'h0, 32'h0, 32'h0},
          SIG_BYTE0, SIG_BYTE1, 1'b1, STATUS_OK, 1'b1, 2'd3},
        // A fully populated table with distinct byte lanes.
        '{'{ACTIVE_MARK, ACTIVE_MARK, ACTIVE_MARK, ACTIVE_MARK},
          '{8'h0B, 8'h0C, 8'h83, 8'h07},
          '{32'h0000_0800, 32'h1234_5678, 32'h89AB_CDEF, 32'hFEDC_BA98},
          '{32'h0001_0000, 32'hA5A5_5A5A, 32'h0F0F_F0F0, 32'h7654_3210},
          SIG_BYTE0, SIG_BYTE1, 1'b0, STATUS_OK, 1'b0, 2'd0},
        // Status bytes close to the active mark must not count as active.
        '{'{8'h81, 8'h7F, 8'h00, 8'hFF}, '{8'h83, 8'h83, 8'h83, 8'h83},
          '{32'h0000_003F, 32'h0000_0001, 32'h8000_0000, 32'h7FFF_FFFF},
          '{32'h0000_1000, 32'hDEAD_BEEF, 32'h0000_00FF, 32'hFF00_0000},
          SIG_BYTE0, SIG_BYTE1, 1'b0, STATUS_OK, 1'b0, 2'd0},
        // Second signature byte repeats the first; the search still runs.
        '{'{8'h00, ACTIVE_MARK, 8'h00, 8'h00}, '{8'h00, 8'h83, 8'h00, 8'h00},
          '{32'h0, 32'h0000_0800, 32'h0, 32'h0}, '{32'h0, 32'h0010_0000, 32'h0, 32'h0},
          SIG_BYTE0, SIG_BYTE0, 1'b1, STATUS_BAD_SIG, 1'b1, 2'd1},
        // First signature byte wrong.
        '{'{8'h00, 8'h00, 8'h00, 8'h00}, '{8'h00, 8'h00, 8'h00, 8'h00},
          '{32'h0, 32'h0, 32'h0, 32'h0}, '{32'h0, 32'h0, 32'h0, 32'h0},
          SIG_BYTE1, SIG_BYTE1, 1'b1, STATUS_BAD_SIG, 1'b0, 2'd0},
        // Signature bytes swapped.
        '{'{8'h00, 8'h00, ACTIVE_MARK, 8'h00}, '{8'h00, 8'h00, 8'h05, 8'h00},
          '{32'h0, 32'h0, 32'h0000_2000, 32'h0}, '{32'h0, 32'h0, 32'h0000_4000, 32'h0},
          SIG_BYTE1, SIG_BYTE0, 1'b1, STATUS_BAD_SIG, 1'b1, 2'd2},
        // Signature off by one bit in the first byte.
        '{'{ACTIVE_MARK, 8'h00, 8'h00, 8'h00}, '{8'h0E, 8'h00, 8'h00, 8'h00},
          '{32'h0102_0304, 32'h0, 32'h0, 32'h0}, '{32'h0506_0708, 32'h0, 32'h0, 32'h0},
          8'h54, SIG_BYTE1, 1'b0, STATUS_OK, 1'b0, 2'd0},
        // Signature off by one bit in the second byte.
        '{'{8'h00, 8'h00, 8'h00, ACTIVE_MARK}, '{8'h00, 8'h00, 8'h00, 8'h0F},
          '{32'h0, 32'h0, 32'h0, 32'hC0FF_EE00}, '{32'h0, 32'h0, 32'h0, 32'h0000_0001},
          SIG_BYTE0, 8'hAB, 1'b0, STATUS_OK, 1'b0, 2'd0},
        // Every captured bit set; 0xFF is not the active mark.
        '{'{8'hFF, 8'hFF, 8'hFF, 8'hFF}, '{8'hFF, 8'hFF, 8'hFF, 8'hFF},
          '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF},
          '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF},
          SIG_BYTE0, SIG_BYTE1, 1'b1, STATUS_OK, 1'b0, 2'd0},
        // Every field rewritten after the all-ones sector: nothing is stale.
        '{'{8'h00, 8'h00, ACTIVE_MARK, ACTIVE_MARK}, '{8'hEE, 8'h00, 8'h0C, 8'h07},
          '{32'h0000_0001, 32'h0, 32'h0040_0000, 32'h0080_0000},
          '{32'hFFFF_FFFE, 32'h0, 32'h0004_0000, 32'h0000_8000},
          SIG_BYTE0, SIG_BYTE1, 1'b0, STATUS_OK, 1'b0, 2'd0}
    };

    logic clk;
    logic rst_n;

    mbrp_byte_if   sector_bus ();
    mbrp_result_if result_bus ();

    mbr_partition_table_parser_top i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .sector (sector_bus),
        .result (result_bus)
    );

    // Results still owed by the block, oldest first.
    part_result_t expected_results [$];
    // Results the parser model produced for the byte just accepted.
    part_result_t parsed_results [$];

    int mismatch_count = 0;
    int checked_count  = 0;

    // Parser model state: byte offset, captured table and the first
    // signature byte check.
    logic [8:0]  pos_cnt;
    logic        tbl_active [4];
    logic [7:0]  tbl_type [4];
    logic [31:0] tbl_lba [4];
    logic [31:0] tbl_len [4];
    logic        sig_head_ok;

    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2.0) clk = ~clk;
    end

    // Hard stop in case the block stops moving transactions.
    initial
    begin
        #(CLK_PERIOD * 3_000_000);
        $display("*** FAILED ***");
        $finish;
    end

    // Length of one idle stretch: mostly a few cycles, now and then a long one.
    function automatic int idle_length();
        if ($urandom_range(0, 9) < 8)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [31:0] random_word();
        case ($urandom_range(0, 7))
            0: return 32'h0;
            1: return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    function automatic string describe(part_result_t r);
        return $sformatf({"status=%0d entry=%0d boot=%0d type=%02h lba=%08h len=%08h ",
                          "found=%0d active=%0d last=%0d"},
                         r.status, r.entry_index, r.bootable, r.part_type, r.first_lba,
                         r.lba_count, r.active_found, r.active_index, r.last);
    endfunction

    // Advance the parser model by one sector byte. On the closing byte of a
    // sector the results it reports are appended to parsed_results.
    task automatic parse_byte(input logic [7:0] b);
        logic [8:0]   pos;
        int           rel;
        int           e;
        int           off;
        logic         found;
        logic [1:0]   first_active;
        part_result_t r;

        pos = pos_cnt;
        pos_cnt = (pos == LAST_POS) ? 9'd0 : pos + 9'd1;

        if (pos >= TABLE_BASE && pos < SIG_POS)
        begin
            rel = int'(pos - TABLE_BASE);
            e   = rel / 16;
            off = rel % 16;
            // CHS bytes fall through every branch and are dropped.
            if (off == OFF_STATUS)
                tbl_active[e] = (b == ACTIVE_MARK);
            else if (off == OFF_TYPE)
                tbl_type[e] = b;
            else if (off >= OFF_LBA_FIRST && off < OFF_LEN_FIRST)
                tbl_lba[e][8 * (off - OFF_LBA_FIRST) +: 8] = b;
            else if (off >= OFF_LEN_FIRST)
                tbl_len[e][8 * (off - OFF_LEN_FIRST) +: 8] = b;
        end
        else if (pos == SIG_POS)
            sig_head_ok = (b == SIG_BYTE0);
        else if (pos == LAST_POS)
        begin
            // Scan downwards so that the lowest qualifying entry wins.
            found = 1'b0;
            first_active = 2'd0;
            for (int i = NUM_ENTRIES - 1; i >= 0; i--)
            begin
                if (tbl_active[i] && tbl_type[i] != 8'h00)
                begin
                    found = 1'b1;
                    first_active = i[1:0];
                end
            end
            if (sig_head_ok && b == SIG_BYTE1)
            begin
                for (int i = 0; i < NUM_ENTRIES; i++)
                begin
                    r.status       = STATUS_OK;
                    r.entry_index  = i[1:0];
                    r.bootable     = tbl_active[i];
                    r.part_type    = tbl_type[i];
                    r.first_lba    = tbl_lba[i];
                    r.lba_count    = tbl_len[i];
                    r.active_found = found;
                    r.active_index = first_active;
                    r.last         = (i[1:0] == LAST_ENTRY);
                    parsed_results.push_back(r);
                end
            end
            else
            begin
                r = '0;
                r.status       = STATUS_BAD_SIG;
                r.active_found = found;
                r.active_index = first_active;
                r.last         = 1'b1;
                parsed_results.push_back(r);
            end
        end
    endtask

    // Offer one byte, after an optional gap, and return at the clock edge at
    // which the transaction is accepted.
    task automatic put_byte(input logic [7:0] b, input logic calm);
        int gap;

        gap = (calm || $urandom_range(0, 3) != 0) ? 0 : idle_length();
        if (gap > 0)
        begin
            sector_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        sector_bus.valid       <= 1'b1;
        sector_bus.sector_byte <= b;
        do
            @(posedge clk);
        while (!sector_bus.ready);
    endtask

    // Lay out one sector image from a row, stream it and record what the block
    // owes for it.
    task automatic send_sector(input sector_row_t row);
        logic [7:0]   image [512];
        int           base;
        logic         calm;
        part_result_t r;

        foreach (image[k])
            image[k] = 8'($urandom_range(0, 255));
        for (int e = 0; e < NUM_ENTRIES; e++)
        begin
            base = int'(TABLE_BASE) + 16 * e;
            image[base + OFF_STATUS] = row.boot[e];
            image[base + OFF_TYPE]   = row.ptype[e];
            for (int l = 0; l < 4; l++)
            begin
                image[base + OFF_LBA_FIRST + l] = row.lba[e][8 * l +: 8];
                image[base + OFF_LEN_FIRST + l] = row.len[e][8 * l +: 8];
            end
        end
        image[SIG_POS]  = row.sig0;
        image[LAST_POS] = row.sig1;

        // About one sector in four goes through without any gaps.
        calm = ($urandom_range(0, 3) == 0);
        parsed_results.delete();
        foreach (image[k])
        begin
            put_byte(image[k], calm);
            parse_byte(image[k]);
        end

        if (!row.typed)
        begin
            foreach (parsed_results[k])
                expected_results.push_back(parsed_results[k]);
        end
        else if (row.exp_status == STATUS_BAD_SIG)
        begin
            r = '0;
            r.status       = STATUS_BAD_SIG;
            r.active_found = row.exp_found;
            r.active_index = row.exp_index;
            r.last         = 1'b1;
            expected_results.push_back(r);
        end
        else
        begin
            // A good signature reports the table back as written in the row.
            for (int e = 0; e < NUM_ENTRIES; e++)
            begin
                r.status       = STATUS_OK;
                r.entry_index  = e[1:0];
                r.bootable     = (row.boot[e] == ACTIVE_MARK);
                r.part_type    = row.ptype[e];
                r.first_lba    = row.lba[e];
                r.lba_count    = row.len[e];
                r.active_found = row.exp_found;
                r.active_index = row.exp_index;
                r.last         = (e[1:0] == LAST_ENTRY);
                expected_results.push_back(r);
            end
        end
    endtask

    // Random sector: mostly a good signature and plausible entries, with
    // some noise in the status bytes and now and then a broken signature.
    function automatic sector_row_t random_row();
        sector_row_t row;

        row = '0;
        for (int e = 0; e < NUM_ENTRIES; e++)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4: row.boot[e] = ACTIVE_MARK;
                5, 6, 7:       row.boot[e] = 8'h00;
                default:       row.boot[e] = 8'($urandom_range(0, 255));
            endcase
            row.ptype[e] = ($urandom_range(0, 2) == 0) ? 8'h00 : 8'($urandom_range(0, 255));
            row.lba[e]   = random_word();
            row.len[e]   = random_word();
        end
        row.sig0 = SIG_BYTE0;
        row.sig1 = SIG_BYTE1;
        case ($urandom_range(0, 9))
            8: row.sig0 = 8'($urandom_range(0, 255));
            9: row.sig1 = 8'($urandom_range(0, 255));
            default: ;
        endcase
        return row;
    endfunction

    task automatic check_result(input part_result_t got);
        part_result_t want;
        string        bad;

        checked_count++;
        if (expected_results.size() == 0)
        begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
                $display("%0t: result with nothing expected: %s", $realtime, describe(got));
            return;
        end
        want = expected_results.pop_front();
        bad = "";
        if (got.status !== want.status)             bad = {bad, " status"};
        if (got.entry_index !== want.entry_index)   bad = {bad, " entry_index"};
        if (got.bootable !== want.bootable)         bad = {bad, " bootable"};
        if (got.part_type !== want.part_type)       bad = {bad, " part_type"};
        if (got.first_lba !== want.first_lba)       bad = {bad, " first_lba"};
        if (got.lba_count !== want.lba_count)       bad = {bad, " lba_count"};
        if (got.active_found !== want.active_found) bad = {bad, " active_found"};
        if (got.active_index !== want.active_index) bad = {bad, " active_index"};
        if (got.last !== want.last)                 bad = {bad, " last"};
        if (bad != "")
        begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
            begin
                $display("%0t: mismatch in%s", $realtime, bad);
                $display("    expected %s", describe(want));
                $display("    actual   %s", describe(got));
            end
        end
    endtask

    // Result side: checks every transaction and varies ready. Once, well into
    // the random sectors, it holds ready low for a long stretch so that the
    // snapshot queue fills and the closing byte of a sector is held back.
    initial
    begin : result_sink
        int           stall_left;
        int           mode_cycles;
        logic         calm;
        logic         long_hold_done;
        part_result_t got;

        stall_left     = 0;
        mode_cycles    = 0;
        calm           = 1'b0;
        long_hold_done = 1'b0;
        result_bus.ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (result_bus.valid && result_bus.ready)
            begin
                got.status       = result_bus.status;
                got.entry_index  = result_bus.entry_index;
                got.bootable     = result_bus.bootable;
                got.part_type    = result_bus.part_type;
                got.first_lba    = result_bus.first_lba;
                got.lba_count    = result_bus.lba_count;
                got.active_found = result_bus.active_found;
                got.active_index = result_bus.active_index;
                got.last         = result_bus.last;
                check_result(got);
            end
            if (!long_hold_done && checked_count >= HOLD_AFTER_RESULTS)
            begin
                long_hold_done = 1'b1;
                stall_left = LONG_HOLD_CYCLES;
            end
            // Each time the mode counter wraps, decide afresh whether the next stretch is calm.
            mode_cycles++;
            if (mode_cycles == 256)
            begin
                mode_cycles = 0;
                calm = ($urandom_range(0, 3) == 0);
            end
            if (stall_left == 0 && !calm && $urandom_range(0, 4) == 0)
                stall_left = idle_length();
            if (stall_left > 0)
            begin
                result_bus.ready <= 1'b0;
                stall_left--;
            end
            else
                result_bus.ready <= 1'b1;
        end
    end

    // Sector side: reset, the directed table, a pause until every result has
    // come back, the random sectors, then the drain and the verdict.
    initial
    begin : byte_source
        pos_cnt     = '0;
        sig_head_ok = 1'b0;
        foreach (tbl_active[e])
        begin
            tbl_active[e] = 1'b0;
            tbl_type[e]   = '0;
            tbl_lba[e]    = '0;
            tbl_len[e]    = '0;
        end

        rst_n                  <= 1'b0;
        sector_bus.valid       <= 1'b0;
        sector_bus.sector_byte <= '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        foreach (DIRECTED[k])
            send_sector(DIRECTED[k]);

        // The sender goes quiet until the block has delivered everything.
        sector_bus.valid <= 1'b0;
        do
            @(posedge clk);
        while (expected_results.size() != 0);

        repeat (RANDOM_SECTORS)
            send_sector(random_row());
        sector_bus.valid <= 1'b0;

        do
            @(posedge clk);
        while (expected_results.size() != 0);
        // A few more cycles so that any stray extra transaction is caught.
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
